// ===== rtl/eia3_pkg.sv =====
// Shared constants and types, including the keystream window type, for the 128-EIA3 MAC accumulator.
// Used by every module under rtl/; depends on nothing.
package eia3_pkg;

    localparam int WORD_W          = 32;
    localparam int LEN_W           = 16;
    localparam int IDX_W           = 12;
    localparam int OFF_W           = 5;
    localparam int MAX_LENGTH_BITS = 65535;
    localparam int LANES           = 32;
    localparam int TERMS           = LANES + 1;
    localparam int TREE_LEVELS     = $clog2(TERMS);
    localparam int TREE_LEAVES     = 1 << TREE_LEVELS;

    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LENGTH_BITS);
    localparam logic [IDX_W-1:0] IDX_LIMIT = {IDX_W{1'b1}};

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [2*WORD_W-1:0] window_t;

    // Work handed from the lane stage to the accumulator stage
    typedef struct packed {
        logic  first;
        logic  emit;
        word_t contrib;
        word_t keystream;
    } stage_t;

endpackage

// ===== rtl/eia3_lane.sv =====
// One hash lane: top word of the 64-bit keystream window shifted by an offset.
// Depends on eia3_pkg.
module eia3_lane
(
    input  eia3_pkg::window_t              window,
    input  logic [eia3_pkg::OFF_W-1:0]     offset,
    input  logic                           enable,
    output eia3_pkg::word_t                term
);

    eia3_pkg::window_t shifted;

    assign shifted = window << offset;
    assign term    = enable ? shifted[2*eia3_pkg::WORD_W-1:eia3_pkg::WORD_W] : '0;

endmodule

// ===== rtl/eia3_merge.sv =====
// XOR tree that folds the lane terms into one contribution word.
// Depends on eia3_pkg.
module eia3_merge
(
    input  eia3_pkg::word_t terms [eia3_pkg::TERMS],
    output eia3_pkg::word_t contrib
);

    eia3_pkg::word_t level [eia3_pkg::TREE_LEVELS+1][eia3_pkg::TREE_LEAVES];

    always_comb
    begin
        for (int l = 0; l <= eia3_pkg::TREE_LEVELS; l++)
        begin
            for (int i = 0; i < eia3_pkg::TREE_LEAVES; i++)
            begin
                level[l][i] = '0;
            end
        end
        for (int i = 0; i < eia3_pkg::TERMS; i++)
        begin
            level[0][i] = terms[i];
        end
        for (int l = 0; l < eia3_pkg::TREE_LEVELS; l++)
        begin
            for (int i = 0; i < (eia3_pkg::TREE_LEAVES >> (l + 1)); i++)
            begin
                level[l+1][i] = level[l][2*i] ^ level[l][2*i+1];
            end
        end
    end

    assign contrib = level[eia3_pkg::TREE_LEVELS][0];

endmodule

// ===== rtl/eia3_accum.sv =====
// Accumulator stage: folds each contribution in and registers the tag.
// Depends on eia3_pkg.
module eia3_accum
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             stage_valid,
    input  eia3_pkg::stage_t stage,
    output logic             stage_take,
    output logic             out_valid,
    input  logic             out_ready,
    output eia3_pkg::word_t  mac
);

    eia3_pkg::word_t acc_reg;
    eia3_pkg::word_t acc_next;
    eia3_pkg::word_t mac_reg;
    logic            out_valid_reg;

    // A non-emitting transaction never needs the output slot
    assign stage_take = stage_valid && (!stage.emit || !out_valid_reg || out_ready);
    assign acc_next   = (stage.first ? '0 : acc_reg) ^ stage.contrib;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (stage_take)
            begin
                acc_reg <= acc_next;
                if (stage.emit)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take && stage.emit)
        begin
            mac_reg <= acc_next ^ stage.keystream;
        end
    end

    assign out_valid = out_valid_reg;
    assign mac       = mac_reg;

endmodule

// ===== rtl/eia3_mac_accumulator_top.sv =====
// 128-EIA3 universal-hash MAC accumulator, 32 hash lanes and an XOR merge tree.
// The final word's transaction is registered in the lane stage, then its tag in the accumulator.
// Accepts one word per cycle unless stalled; the lane stage and accumulator are each
// registered, and a held tag only stalls the next emitting word.
// Reset (rst_n, asynchronous): accumulator and history cleared, block idle
// until a word with first set.
module eia3_mac_accumulator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        first,
    input  logic [15:0] message_length,
    input  logic [31:0] keystream_word,
    input  logic [31:0] message_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] mac
);

    eia3_pkg::word_t                 prev_ks_reg;
    eia3_pkg::word_t                 prev_msg_reg;
    logic [eia3_pkg::IDX_W-1:0]      word_index_reg;
    logic [eia3_pkg::LEN_W-1:0]      held_length_reg;
    logic                            finished_reg;
    logic                            stage_valid_reg;
    eia3_pkg::stage_t                stage_reg;
    logic                            stage_take;

    logic                            accept;
    logic                            active;
    logic [eia3_pkg::LEN_W-1:0]      len_eff;
    logic [eia3_pkg::IDX_W-1:0]      idx_eff;
    logic [eia3_pkg::IDX_W-1:0]      prev_idx;
    logic [eia3_pkg::IDX_W-1:0]      len_word;
    logic [eia3_pkg::IDX_W-1:0]      last_idx;
    logic                            has_prev;
    logic                            word_full;
    logic                            word_part;
    logic                            emit;
    eia3_pkg::window_t               window;
    eia3_pkg::word_t                 terms [eia3_pkg::TERMS];
    eia3_pkg::word_t                 contrib;
    logic [eia3_pkg::LANES-1:0]      lane_en;

    assign in_ready = !stage_valid_reg || stage_take;
    assign accept   = in_valid && in_ready;
    assign active   = accept && (first || !finished_reg);

    always_comb
    begin
        if (first)
        begin
            len_eff = (message_length > eia3_pkg::LEN_MAX) ? eia3_pkg::LEN_MAX : message_length;
            idx_eff = '0;
        end
        else
        begin
            len_eff = held_length_reg;
            idx_eff = word_index_reg;
        end
        has_prev  = idx_eff != '0;
        prev_idx  = idx_eff - 1'b1;
        len_word  = eia3_pkg::IDX_W'(len_eff[eia3_pkg::LEN_W-1:eia3_pkg::OFF_W]);
        word_full = has_prev && (prev_idx < len_word);
        word_part = has_prev && (prev_idx == len_word);
        last_idx  = eia3_pkg::IDX_W'(({1'b0, len_eff} + (eia3_pkg::LEN_W+1)'(63))
                                     >> eia3_pkg::OFF_W);
        emit      = idx_eff == last_idx;
        for (int b = 0; b < eia3_pkg::LANES; b++)
        begin
            lane_en[b] = prev_msg_reg[eia3_pkg::LANES-1-b]
                && (word_full || (word_part
                    && (eia3_pkg::OFF_W'(b) < len_eff[eia3_pkg::OFF_W-1:0])));
        end
    end

    assign window = {prev_ks_reg, keystream_word};

    for (genvar g = 0; g < eia3_pkg::LANES; g++)
    begin : g_lane
        eia3_lane u_lane
        (
            .window (window),
            .offset (eia3_pkg::OFF_W'(g)),
            .enable (lane_en[g]),
            .term   (terms[g])
        );
    end

    // Extra term taken at the length offset, in the word holding the length
    eia3_lane u_len_lane
    (
        .window (window),
        .offset (len_eff[eia3_pkg::OFF_W-1:0]),
        .enable (word_part),
        .term   (terms[eia3_pkg::LANES])
    );

    eia3_merge u_merge
    (
        .terms   (terms),
        .contrib (contrib)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ks_reg     <= '0;
            prev_msg_reg    <= '0;
            word_index_reg  <= '0;
            held_length_reg <= '0;
            finished_reg    <= 1'b1;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_take)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (active)
            begin
                stage_valid_reg <= 1'b1;
                held_length_reg <= len_eff;
                finished_reg    <= emit;
                prev_ks_reg     <= keystream_word;
                prev_msg_reg    <= message_word;
                // Hold the index once it saturates
                word_index_reg  <= (idx_eff == eia3_pkg::IDX_LIMIT) ? idx_eff
                                                                     : idx_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            stage_reg.first     <= first;
            stage_reg.emit      <= emit;
            stage_reg.contrib   <= contrib;
            stage_reg.keystream <= keystream_word;
        end
    end

    eia3_accum u_accum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid_reg),
        .stage       (stage_reg),
        .stage_take  (stage_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mac         (mac)
    );

endmodule

// ===== tb/sv/eia3_mac_accumulator_top_tb.sv =====
// Self-checking testbench for eia3_mac_accumulator_top: random and directed word
// streams, with each tag compared against a cycle-free predictor of the 128-EIA3 hash.
// Depends on eia3_pkg and the RTL under rtl/.
module eia3_mac_accumulator_top_tb;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       first;
    logic [eia3_pkg::LEN_W-1:0] message_length;
    eia3_pkg::word_t            keystream_word;
    eia3_pkg::word_t            message_word;
    logic                       out_valid;
    logic                       out_ready;
    eia3_pkg::word_t            mac;

    // Idling and back-pressure controls shared by the driving processes
    int unsigned     tx_idle_max;
    int unsigned     rx_idle_max;
    int unsigned     rx_hold;
    int unsigned     rx_wait;
    int unsigned     err_count;
    int unsigned     words_used;
    int unsigned     drain_cycles;
    eia3_pkg::word_t tag_expected;

    // Expected tags, oldest first
    eia3_pkg::word_t tag_q[$];

    // Predictor state
    eia3_pkg::word_t            hash_acc;
    eia3_pkg::word_t            prev_keystream;
    eia3_pkg::word_t            prev_message;
    logic [eia3_pkg::IDX_W-1:0] word_idx;
    int unsigned                held_len;
    logic                       msg_done;

    eia3_mac_accumulator_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first          (first),
        .message_length (message_length),
        .keystream_word (keystream_word),
        .message_word   (message_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mac            (mac)
    );

    always #5 clk = ~clk;

    // Advance the hash by one accepted word; returns 0 if the block ignores it
    function automatic bit hash_word(input logic f, input logic [eia3_pkg::LEN_W-1:0] len,
                                     input eia3_pkg::word_t ks, input eia3_pkg::word_t mw);
        eia3_pkg::window_t span;
        eia3_pkg::window_t shifted;
        int unsigned       base;
        int unsigned       last;
        if (f)
        begin
            held_len = (len > eia3_pkg::LEN_MAX) ? eia3_pkg::LEN_MAX : len;
            hash_acc = '0;
            word_idx = '0;
            msg_done = 1'b0;
        end
        else if (msg_done)
            return 1'b0;
        last = (held_len + 63) >> 5;
        if (word_idx != 0)
        begin
            span = {prev_keystream, ks};
            base = (int'(word_idx) - 1) * 32;
            for (int b = 0; b < 32; b++)
            begin
                if (base + b >= held_len)
                    break;
                if (prev_message[31-b])
                begin
                    shifted = span << b;
                    hash_acc ^= shifted[63:32];
                end
            end
            // the length position adds the window at its own offset
            if ((held_len >> 5) == int'(word_idx) - 1)
            begin
                shifted = span << (held_len & 31);
                hash_acc ^= shifted[63:32];
            end
        end
        if (word_idx == last)
        begin
            tag_q.push_back(hash_acc ^ ks);
            msg_done = 1'b1;
        end
        prev_keystream = ks;
        prev_message   = mw;
        if (word_idx != eia3_pkg::IDX_LIMIT)
            word_idx++;
        return 1'b1;
    endfunction

    task automatic send_word(input logic f, input logic [eia3_pkg::LEN_W-1:0] len,
                             input eia3_pkg::word_t ks, input eia3_pkg::word_t mw);
        int unsigned gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        first          <= f;
        message_length <= len;
        keystream_word <= ks;
        message_word   <= mw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (hash_word(f, len, ks, mw))
            words_used++;
    endtask

    // Send a message of len bits; count limits the words sent (0 sends all of them)
    task automatic send_message(input int unsigned len, input int unsigned count,
                                input bit fixed, input eia3_pkg::word_t ks_val,
                                input eia3_pkg::word_t mw_val);
        int unsigned     total;
        eia3_pkg::word_t ks;
        eia3_pkg::word_t mw;
        total = ((len + 63) >> 5) + 1;
        if (count == 0 || count > total)
            count = total;
        for (int unsigned n = 0; n < count; n++)
        begin
            ks = fixed ? ks_val : $urandom();
            mw = fixed ? mw_val : $urandom();
            send_word(n == 0, (n == 0) ? eia3_pkg::LEN_W'(len)
                                       : eia3_pkg::LEN_W'($urandom()), ks, mw);
        end
    endtask

    task automatic test_directed();
        // idle after reset: words without first are dropped
        send_word(1'b0, 16'hFFFF, '1, '1);
        send_word(1'b0, 16'h0000, '0, '0);
        // zero length: tag is z[0] ^ z[1]
        send_message(0, 0, 1'b1, '1, '1);
        send_message(1, 0, 1'b1, '0, '1);
        send_message(32, 0, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
        send_message(63, 0, 1'b0, '0, '0);
        // words after the tag are ignored
        send_word(1'b0, 16'h1234, $urandom(), $urandom());
        send_word(1'b0, 16'hEDCB, $urandom(), $urandom());
        // abandon a message part-way and restart
        send_message(100, 2, 1'b0, '0, '0);
        send_message(5, 0, 1'b0, '0, '0);
        send_message(eia3_pkg::MAX_LENGTH_BITS, 2, 1'b1, '1, '1);
        send_message(31, 0, 1'b0, '0, '0);
    endtask

    // Long message spanning several hundred words, kept within the word budget
    task automatic test_longest_message();
        send_message(16000, 0, 1'b0, '0, '0);
    endtask

    task automatic test_backpressure();
        tx_idle_max = 0;
        rx_hold     = 400;
        repeat (40) send_message($urandom_range(0, 40), 0, 1'b0, '0, '0);
        tx_idle_max = 17;
    endtask

    task automatic test_random_traffic();
        int unsigned kind;
        while (words_used < 1050)
        begin
            // switch between idling and back-to-back stretches now and then
            if ($urandom_range(0, 19) == 0)
            begin
                tx_idle_max = $urandom_range(0, 1) ? 17 : 0;
                rx_idle_max = $urandom_range(0, 1) ? 17 : 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 60)
                send_message($urandom_range(0, 256), 0, 1'b0, '0, '0);
            else if (kind < 75)
                send_message($urandom_range(0, 2048), 0, 1'b0, '0, '0);
            else if (kind < 85)
                send_message($urandom_range(0, 65535), $urandom_range(1, 4), 1'b0, '0, '0);
            else if (kind < 95)
            begin
                if (msg_done)
                    repeat ($urandom_range(1, 3))
                        send_word(1'b0, eia3_pkg::LEN_W'($urandom()), $urandom(), $urandom());
            end
            else
                send_message($urandom_range(0, 512), 0, 1'b1, $urandom(), '1);
        end
        tx_idle_max = 17;
        rx_idle_max = 17;
    endtask

    // Receiver: draw a stall per tag, or hold off for a long stretch on request
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (rx_hold > 0)
            begin
                rx_wait = rx_hold;
                rx_hold = 0;
            end
            else
                rx_wait = $urandom_range(0, rx_idle_max);
            if (rx_wait > 0)
                out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (rx_wait > 0)
                rx_wait--;
            if (rx_wait == 0)
                out_ready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_wait = rx_hold;
            rx_hold = 0;
            out_ready <= 1'b0;
        end
    end

    // Compare each tag transaction with the oldest expected tag
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tag_q.size() == 0)
            begin
                $display("%0t: unexpected mac, expected none, actual %08h", $time, mac);
                err_count++;
            end
            else
            begin
                tag_expected = tag_q.pop_front();
                if (mac !== tag_expected)
                begin
                    $display("%0t: mac mismatch, expected %08h, actual %08h",
                             $time, tag_expected, mac);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        first          = 1'b0;
        message_length = '0;
        keystream_word = '0;
        message_word   = '0;
        out_ready      = 1'b0;
        rx_wait        = 2;
        rx_hold        = 0;
        tx_idle_max    = 17;
        rx_idle_max    = 17;
        err_count      = 0;
        words_used     = 0;
        hash_acc       = '0;
        prev_keystream = '0;
        prev_message   = '0;
        word_idx       = '0;
        held_len       = 0;
        msg_done       = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_longest_message();
        test_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        drain_cycles = 0;
        while (tag_q.size() != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);
        if (tag_q.size() != 0)
        begin
            $display("%0t: mac missing, expected %08h, actual none (%0d outstanding)",
                     $time, tag_q[0], tag_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
